FILE: hw/rtl/atb_pkg.sv
`timescale 1ns / 1ps

package atb_pkg;

    localparam int ALARM_COUNT = 8;
    localparam int ALARM_IW    = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam int MASK_W      = 8;
    localparam int WIDE_W      = (ALARM_COUNT > MASK_W) ? ALARM_COUNT : MASK_W;
    localparam int CNT_W       = 32;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [MASK_W-1:0] HANDLER_RESET = 8'hFF;

    typedef logic [ALARM_COUNT-1:0] t_alarm_vec;
    typedef logic [CNT_W-1:0]       t_count;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_ctl_state;

    typedef struct packed {
        logic load;
    } t_dp_cmd;

endpackage

FILE: hw/rtl/alarm_timer_bank_unit.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      i_in_valid/o_in_stall  i_cmd, i_alarm_id, i_period, i_periodic
// out      output     o_out_valid/i_out_stall o_fired_mask, o_active_mask
// cfg      input      i_cfg_we               i_cfg_wdata (handler mask)
//
// One word per cycle while no result is stalled; the result appears in the cycle after
// acceptance, from the output register. A tick updates all alarm counters in parallel.
// Synchronous active-low reset clears all alarms; the handler mask resets to all ones.
// While a result is stalled, an input word is stalled too; otherwise a new word is taken
// in the same cycle the old result leaves.

module alarm_timer_bank_unit import atb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [4:0]        i_alarm_id,
    input  logic [CNT_W-1:0]  i_period,
    input  logic              i_periodic,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_fired_mask,
    output logic [MASK_W-1:0] o_active_mask,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;

    atb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    atb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_ctl     (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_alarm_id    (i_alarm_id),
        .i_period      (i_period),
        .i_periodic    (i_periodic),
        .o_fired_mask  (o_fired_mask),
        .o_active_mask (o_active_mask)
    );

endmodule

FILE: hw/rtl/atb_ctrl.sv
`timescale 1ns / 1ps

module atb_ctrl import atb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // output word register empties when taken, refills on a new word
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (i_in_valid) begin
                    n_state = ST_FULL;
                end
            end
            ST_FULL: begin
                if (!i_out_stall && !i_in_valid) begin
                    n_state = ST_EMPTY;
                end
            end
            default: begin
                n_state = ST_EMPTY;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b0;
        o_out_valid = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_EMPTY: begin
                w_load = i_in_valid;
            end
            ST_FULL: begin
                o_out_valid = 1'b1;
                o_in_stall  = i_out_stall;
                w_load      = i_in_valid && !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        o_cmd.load = w_load;
    end

endmodule

FILE: hw/rtl/atb_datapath.sv
`timescale 1ns / 1ps

module atb_datapath import atb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd_ctl,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    input  logic [1:0]        i_cmd,
    input  logic [4:0]        i_alarm_id,
    input  logic [CNT_W-1:0]  i_period,
    input  logic              i_periodic,
    output logic [MASK_W-1:0] o_fired_mask,
    output logic [MASK_W-1:0] o_active_mask
);

    t_count            r_count  [ALARM_COUNT];
    t_count            n_count  [ALARM_COUNT];
    t_count            r_reload [ALARM_COUNT];
    t_alarm_vec        r_repeat;
    t_alarm_vec        r_active;
    t_alarm_vec        n_active;
    t_alarm_vec        w_fired;
    logic [MASK_W-1:0] r_handler;
    logic [MASK_W-1:0] r_fired;
    logic [WIDE_W-1:0] w_handler_wide;
    logic [WIDE_W-1:0] w_fired_wide;
    logic [WIDE_W-1:0] w_active_wide;
    logic              w_id_ok;
    logic [ALARM_IW-1:0] w_id;
    t_count            w_dec;

    assign w_id_ok        = 32'(i_alarm_id) < 32'(ALARM_COUNT);
    assign w_id           = ALARM_IW'(i_alarm_id);
    assign w_handler_wide = WIDE_W'(r_handler);

    always_comb begin
        for (int i = 0; i < ALARM_COUNT; i++) begin
            n_count[i] = r_count[i];
        end
        n_active = r_active;
        w_fired  = '0;
        w_dec    = '0;
        case (i_cmd)
            CMD_TICK: begin
                for (int i = 0; i < ALARM_COUNT; i++) begin
                    w_dec = r_count[i] - 1'b1;
                    if (r_count[i] != '0 && r_active[i]) begin
                        n_count[i] = w_dec;
                        if (w_dec == '0 && w_handler_wide[i]) begin
                            w_fired[i] = 1'b1;
                            if (r_repeat[i]) begin
                                n_count[i] = r_reload[i];
                            end else begin
                                n_active[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_START: begin
                if (w_id_ok) begin
                    n_count[w_id]  = i_period;
                    n_active[w_id] = 1'b1;
                end
            end
            CMD_CANCEL: begin
                if (w_id_ok) begin
                    n_count[w_id]  = '0;
                    n_active[w_id] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handler <= HANDLER_RESET;
            r_active  <= '0;
            r_repeat  <= '0;
            for (int i = 0; i < ALARM_COUNT; i++) begin
                r_count[i]  <= '0;
                r_reload[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_handler <= i_cfg_wdata;
            end
            if (i_cmd_ctl.load) begin
                r_active <= n_active;
                for (int i = 0; i < ALARM_COUNT; i++) begin
                    r_count[i] <= n_count[i];
                end
                if (i_cmd == CMD_START && w_id_ok) begin
                    r_reload[w_id] <= i_period;
                    r_repeat[w_id] <= i_periodic;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_fired <= MASK_W'(WIDE_W'(w_fired));
        end
    end

    assign w_fired_wide  = WIDE_W'(r_fired);
    assign w_active_wide = WIDE_W'(r_active);
    assign o_fired_mask  = w_fired_wide[MASK_W-1:0];
    assign o_active_mask = w_active_wide[MASK_W-1:0];

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import atb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_WORDS = 800;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [MASK_W-1:0] fired;
        logic [MASK_W-1:0] active;
    } t_masks;

    typedef struct packed {
        logic             is_cfg;
        logic [1:0]       cmd;
        logic [4:0]       id;
        logic [CNT_W-1:0] period;
        logic             periodic;
        logic             typed;
        t_masks           want;
    } t_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_cmd       = CMD_TICK;
    logic [4:0]        i_alarm_id  = '0;
    logic [CNT_W-1:0]  i_period    = '0;
    logic              i_periodic  = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [MASK_W-1:0] o_fired_mask;
    logic [MASK_W-1:0] o_active_mask;
    logic              i_cfg_we    = 1'b0;
    logic [MASK_W-1:0] i_cfg_wdata = '0;

    alarm_timer_bank_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_alarm_id    (i_alarm_id),
        .i_period      (i_period),
        .i_periodic    (i_periodic),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_fired_mask  (o_fired_mask),
        .o_active_mask (o_active_mask),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    t_count            count_left [ALARM_COUNT];
    t_count            reload_val [ALARM_COUNT];
    logic              repeats    [ALARM_COUNT];
    t_alarm_vec        armed;
    logic [MASK_W-1:0] handler_mask;

    t_masks pending_masks[$];
    t_row   script[$];
    int     failures    = 0;
    int     idle_cycles = 0;
    int     stall_left  = 0;
    bit     quiet       = 1'b0;

    function automatic t_masks step_alarms(logic [1:0] cmd, logic [4:0] id,
                                           t_count period, logic periodic);
        t_masks     r;
        t_alarm_vec fired;
        fired = '0;
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < ALARM_COUNT; i++) begin
                    if (armed[i] && count_left[i] != 0) begin
                        count_left[i] = count_left[i] - 1;
                        if (count_left[i] == 0 && i < MASK_W && handler_mask[i % MASK_W]) begin
                            fired[i] = 1'b1;
                            if (repeats[i])
                                count_left[i] = reload_val[i];
                            else
                                armed[i] = 1'b0;
                        end
                    end
                end
            end
            CMD_START: begin
                if (id < ALARM_COUNT) begin
                    reload_val[id] = period;
                    repeats[id]    = periodic;
                    count_left[id] = period;
                    armed[id]      = 1'b1;
                end
            end
            CMD_CANCEL: begin
                if (id < ALARM_COUNT) begin
                    count_left[id] = '0;
                    armed[id]      = 1'b0;
                end
            end
            default: ;
        endcase
        r.fired  = MASK_W'(fired);
        r.active = MASK_W'(armed);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_row plain(logic [1:0] cmd, logic [4:0] id, t_count period,
                                   logic periodic);
        t_row w;
        w = '0;
        w.cmd      = cmd;
        w.id       = id;
        w.period   = period;
        w.periodic = periodic;
        return w;
    endfunction

    function automatic t_row typed_row(logic [1:0] cmd, logic [4:0] id, t_count period,
                                       logic periodic, logic [MASK_W-1:0] fired,
                                       logic [MASK_W-1:0] active);
        t_row w;
        w = plain(cmd, id, period, periodic);
        w.typed       = 1'b1;
        w.want.fired  = fired;
        w.want.active = active;
        return w;
    endfunction

    function automatic t_row cfg_row(logic [MASK_W-1:0] mask);
        t_row w;
        w = '0;
        w.is_cfg = 1'b1;
        w.period = CNT_W'(mask);
        return w;
    endfunction

    function automatic t_row random_row();
        t_row w;
        int   r;
        w = '0;
        r = $urandom_range(0, 99);
        if (r < 55)
            w.cmd = CMD_TICK;
        else if (r < 80)
            w.cmd = CMD_START;
        else if (r < 95)
            w.cmd = CMD_CANCEL;
        else
            w.cmd = CMD_UNUSED;
        if ($urandom_range(0, 19) == 0)
            w.id = 5'($urandom_range(0, 31));
        else
            w.id = 5'($urandom_range(0, ALARM_COUNT - 1));
        r = $urandom_range(0, 99);
        if (r < 75)
            w.period = $urandom_range(0, 6);
        else if (r < 92)
            w.period = $urandom_range(7, 60);
        else if (r < 97)
            w.period = $urandom();
        else
            w.period = '1;
        w.periodic = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic send_word(input t_row w);
        t_masks got;
        int     gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= w.cmd;
        i_alarm_id <= w.id;
        i_period   <= w.period;
        i_periodic <= w.periodic;
        do @(posedge i_clk); while (o_in_stall);
        got = step_alarms(w.cmd, w.id, w.period, w.periodic);
        pending_masks.push_back(w.typed ? w.want : got);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_handlers(input logic [MASK_W-1:0] mask);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        handler_mask = mask;
    endtask

    // result stall
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!quiet)
                stall_left = pick_gap();
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_masks want;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_masks.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected word: fired %h active %h",
                             o_fired_mask, o_active_mask);
            end else begin
                want = pending_masks.pop_front();
                if (o_fired_mask !== want.fired || o_active_mask !== want.active) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("mismatch: fired exp %h got %h, active exp %h got %h",
                                 want.fired, o_fired_mask, want.active, o_active_mask);
                end
            end
        end
    end

    initial begin
        t_row              w;
        int                done_words;
        logic [MASK_W-1:0] settings[$];

        for (int i = 0; i < ALARM_COUNT; i++) begin
            count_left[i] = '0;
            reload_val[i] = '0;
            repeats[i]    = 1'b0;
        end
        armed        = '0;
        handler_mask = HANDLER_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        script.push_back(typed_row(CMD_TICK,   0, 0, 0, 8'h00, 8'h00));
        script.push_back(typed_row(CMD_START,  0, 1, 0, 8'h00, 8'h01));
        script.push_back(typed_row(CMD_TICK,   0, 0, 0, 8'h01, 8'h00));
        script.push_back(typed_row(CMD_START,  7, 2, 1, 8'h00, 8'h80));
        script.push_back(plain(CMD_TICK, 0, 0, 0));
        script.push_back(typed_row(CMD_TICK,   0, 0, 0, 8'h80, 8'h80));
        script.push_back(typed_row(CMD_START,  8, 5, 1, 8'h00, 8'h80));
        script.push_back(typed_row(CMD_START, 31, 32'hFFFF_FFFF, 1, 8'h00, 8'h80));
        script.push_back(typed_row(CMD_CANCEL, 31, 0, 0, 8'h00, 8'h80));
        script.push_back(typed_row(CMD_UNUSED, 3, 32'hFFFF_FFFF, 1, 8'h00, 8'h80));
        script.push_back(typed_row(CMD_CANCEL, 7, 0, 0, 8'h00, 8'h00));
        script.push_back(typed_row(CMD_START,  3, 0, 1, 8'h00, 8'h08));
        script.push_back(typed_row(CMD_TICK,   0, 0, 0, 8'h00, 8'h08));
        script.push_back(plain(CMD_START, 1, 32'hFFFF_FFFF, 1));
        script.push_back(plain(CMD_TICK, 0, 0, 0));
        script.push_back(plain(CMD_START, 2, 1, 1));
        script.push_back(plain(CMD_TICK, 0, 0, 0));
        script.push_back(plain(CMD_TICK, 0, 0, 0));
        script.push_back(plain(CMD_CANCEL, 2, 0, 0));
        script.push_back(plain(CMD_CANCEL, 1, 0, 0));
        script.push_back(plain(CMD_CANCEL, 3, 0, 0));
        // alarm 7 without handler: parks at zero, stays active
        script.push_back(cfg_row(8'h7F));
        script.push_back(typed_row(CMD_START,  7, 1, 1, 8'h00, 8'h80));
        script.push_back(typed_row(CMD_TICK,   0, 0, 0, 8'h00, 8'h80));
        script.push_back(plain(CMD_START, 6, 1, 0));
        script.push_back(typed_row(CMD_TICK,   0, 0, 0, 8'h40, 8'h80));
        script.push_back(plain(CMD_CANCEL, 7, 0, 0));
        script.push_back(cfg_row(8'hFF));

        foreach (script[k]) begin
            if (script[k].is_cfg)
                write_handlers(script[k].period[MASK_W-1:0]);
            else
                send_word(script[k]);
        end

        settings = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h0F,
                     8'hF0, 8'($urandom_range(0, 255)), 8'h55, 8'hFF};
        for (int p = 0; p < settings.size(); p++) begin
            write_handlers(settings[p]);
            quiet = (p % 3 == 2);
            done_words = 0;
            while (done_words < RANDOM_WORDS / settings.size()) begin
                w = random_row();
                send_word(w);
                if (!(w.cmd == CMD_UNUSED || (w.cmd != CMD_TICK && w.id >= ALARM_COUNT)))
                    done_words++;
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end
        quiet = 1'b0;

        wait_drained();
        if (failures == 0 && pending_masks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
